>>> design/gsn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gsn_pkg;

	localparam int DIM_BITS   = 10;
	localparam int IDX_W      = 30;
	localparam int CFG_W      = 11;
	localparam int DIM_W      = DIM_BITS + 1;
	localparam int STEPS      = 3;
	localparam int DIV_STAGES = (IDX_W + STEPS - 1) / STEPS;
	localparam int ADDR_LAT   = 3;
	localparam int LATENCY    = 3 * DIV_STAGES + ADDR_LAT;
	localparam int CMP_W      = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int PLANE_W    = (2 * DIM_BITS + 1 < IDX_W) ? 2 * DIM_BITS + 1 : IDX_W;
	localparam int NBR_N      = 6;

	localparam logic [CMP_W-1:0] DIM_TOP = CMP_W'(1) << DIM_BITS;

	typedef enum logic [1:0] {
		REG_DIM_X = 2'd0,
		REG_DIM_Y = 2'd1,
		REG_DIM_Z = 2'd2
	} reg_idx_t;

	typedef enum int {
		NBR_XM = 0,
		NBR_XP = 1,
		NBR_YM = 2,
		NBR_YP = 3,
		NBR_ZM = 4,
		NBR_ZP = 5
	} nbr_sel_t;

	typedef struct packed {
		logic [DIM_BITS-1:0] x;
		logic [DIM_BITS-1:0] y;
	} coord_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] val;
		coord_t           side;
	} div_in_t;

	typedef struct packed {
		logic                vld;
		logic [IDX_W-1:0]    quo;
		logic [DIM_BITS-1:0] rem;
		coord_t              side;
	} div_out_t;

	typedef struct packed {
		logic                        vld;
		logic [NBR_N-1:0][IDX_W-1:0] nbr;
		logic [NBR_N-1:0]            mask;
	} result_t;

	// extent register to 1 .. 2^DIM_BITS
	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
		logic [CMP_W-1:0] w;
		w = CMP_W'(d);
		if (w == '0) begin
			return DIM_W'(1);
		end
		if (w > DIM_TOP) begin
			return DIM_W'(DIM_TOP);
		end
		return DIM_W'(w);
	endfunction

endpackage
`default_nettype wire

>>> design/gsn_div.sv
`timescale 1ns / 1ps
`default_nettype none
module gsn_div import gsn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_in_t          in_beat,
	input  wire logic [DIM_W-1:0] divisor,
	output div_out_t              out_beat
);

	// restoring division, STEPS quotient bits per stage
	logic                vld_s  [DIV_STAGES];
	logic [IDX_W-1:0]    work_s [DIV_STAGES];
	logic [DIM_BITS-1:0] rem_s  [DIV_STAGES];
	coord_t              side_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic                vld_i;
		logic [IDX_W-1:0]    work_i;
		logic [DIM_BITS-1:0] rem_i;
		coord_t              side_i;
		logic [IDX_W-1:0]    work_n;
		logic [DIM_BITS-1:0] rem_n;

		if (g == 0) begin : g_first
			assign vld_i  = in_beat.vld;
			assign work_i = in_beat.val;
			assign rem_i  = '0;
			assign side_i = in_beat.side;
		end else begin : g_next
			assign vld_i  = vld_s[g-1];
			assign work_i = work_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign side_i = side_s[g-1];
		end

		always_comb begin
			logic [IDX_W-1:0]    w;
			logic [DIM_BITS-1:0] r;
			logic [DIM_W-1:0]    t;
			w = work_i;
			r = rem_i;
			t = '0;
			for (int j = 0; j < STEPS; j++) begin
				if (g * STEPS + j < IDX_W) begin
					t = {r, w[IDX_W-1]};
					w = {w[IDX_W-2:0], 1'b0};
					if (t >= divisor) begin
						t    = t - divisor;
						w[0] = 1'b1;
					end
					r = t[DIM_BITS-1:0];
				end
			end
			work_n = w;
			rem_n  = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			work_s[g] <= work_n;
			rem_s[g]  <= rem_n;
			side_s[g] <= side_i;
		end
	end

	always_comb begin
		out_beat.vld  = vld_s[DIV_STAGES-1];
		out_beat.quo  = work_s[DIV_STAGES-1];
		out_beat.rem  = rem_s[DIV_STAGES-1];
		out_beat.side = side_s[DIV_STAGES-1];
	end

endmodule
`default_nettype wire

>>> design/gsn_addr.sv
`timescale 1ns / 1ps
`default_nettype none
module gsn_addr import gsn_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire div_out_t           zin,
	input  wire logic [DIM_W-1:0]   nx,
	input  wire logic [DIM_W-1:0]   ny,
	input  wire logic [DIM_W-1:0]   nz,
	input  wire logic [PLANE_W-1:0] plane,
	output result_t                 res
);

	logic [DIM_BITS-1:0]         x_c;
	logic [DIM_BITS-1:0]         y_c;
	logic [DIM_BITS-1:0]         z_c;
	logic [DIM_BITS+DIM_W-1:0]   ynx_full;
	logic [DIM_BITS+PLANE_W-1:0] zp_full;
	logic [NBR_N-1:0]            mask_c;

	logic                vld_s1;
	logic [DIM_BITS-1:0] x_s1;
	logic [IDX_W-1:0]    ynx_s1;
	logic [IDX_W-1:0]    zp_s1;
	logic [NBR_N-1:0]    mask_s1;

	logic                vld_s2;
	logic [IDX_W-1:0]    base_s2;
	logic [NBR_N-1:0]    mask_s2;

	logic                        vld_s3;
	logic [NBR_N-1:0][IDX_W-1:0] nbr_s3;
	logic [NBR_N-1:0]            mask_s3;
	logic [NBR_N-1:0][IDX_W-1:0] nbr_c;

	always_comb begin
		x_c      = zin.side.x;
		y_c      = zin.side.y;
		z_c      = zin.rem;
		ynx_full = y_c * nx;
		zp_full  = z_c * plane;
		mask_c[NBR_XM] = (x_c != '0);
		mask_c[NBR_XP] = (DIM_W'(x_c) + DIM_W'(1) < nx);
		mask_c[NBR_YM] = (y_c != '0);
		mask_c[NBR_YP] = (DIM_W'(y_c) + DIM_W'(1) < ny);
		mask_c[NBR_ZM] = (z_c != '0);
		mask_c[NBR_ZP] = (DIM_W'(z_c) + DIM_W'(1) < nz);
	end

	always_comb begin
		nbr_c[NBR_XM] = mask_s2[NBR_XM] ? base_s2 - IDX_W'(1) : '0;
		nbr_c[NBR_XP] = mask_s2[NBR_XP] ? base_s2 + IDX_W'(1) : '0;
		nbr_c[NBR_YM] = mask_s2[NBR_YM] ? base_s2 - IDX_W'(nx) : '0;
		nbr_c[NBR_YP] = mask_s2[NBR_YP] ? base_s2 + IDX_W'(nx) : '0;
		nbr_c[NBR_ZM] = mask_s2[NBR_ZM] ? base_s2 - IDX_W'(plane) : '0;
		nbr_c[NBR_ZP] = mask_s2[NBR_ZP] ? base_s2 + IDX_W'(plane) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= zin.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_c;
		ynx_s1  <= IDX_W'(ynx_full);
		zp_s1   <= IDX_W'(zp_full);
		mask_s1 <= mask_c;
		base_s2 <= IDX_W'(x_s1) + ynx_s1 + zp_s1;
		mask_s2 <= mask_s1;
		nbr_s3  <= nbr_c;
		mask_s3 <= mask_s2;
	end

	always_comb begin
		res.vld  = vld_s3;
		res.nbr  = nbr_s3;
		res.mask = mask_s3;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> $past(zin.vld, ADDR_LAT))
		else $error("result beat without coordinate beat");

	a_x_absent: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> ((mask_s3[NBR_XM] || nbr_s3[NBR_XM] == '0)
			&& (mask_s3[NBR_XP] || nbr_s3[NBR_XP] == '0)))
		else $error("absent x neighbour not zero");

	a_z_absent: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> ((mask_s3[NBR_ZM] || nbr_s3[NBR_ZM] == '0)
			&& (mask_s3[NBR_ZP] || nbr_s3[NBR_ZP] == '0)))
		else $error("absent z neighbour not zero");

endmodule
`default_nettype wire

>>> design/grid_six_neighbor_index.sv
// Channel   Handshake               Ports
// -------   ---------------------   ---------------------------------------------
// in        start & !busy           node_index
// out       done (one-cycle beat)   neighbor_{x,y,z}_{minus,plus}, present_mask
// cfg       wr_en                   wr_index, wr_data
//
// One beat per cycle in and out; the path runs through three chained restoring
// dividers of 3 quotient bits per stage, then registered address stages of multiply,
// add and neighbour offset.
// busy never rises; the receiver cannot stall and no stage ever holds.
// Reset clears valid bits and sets all extents to 1.
`timescale 1ns / 1ps
`default_nettype none
module grid_six_neighbor_index import gsn_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [IDX_W-1:0] node_index,
	output logic                  done,
	output logic [IDX_W-1:0]      neighbor_x_minus,
	output logic [IDX_W-1:0]      neighbor_x_plus,
	output logic [IDX_W-1:0]      neighbor_y_minus,
	output logic [IDX_W-1:0]      neighbor_y_plus,
	output logic [IDX_W-1:0]      neighbor_z_minus,
	output logic [IDX_W-1:0]      neighbor_z_plus,
	output logic [NBR_N-1:0]      present_mask,
	input  wire logic             wr_en,
	input  wire logic [1:0]       wr_index,
	input  wire logic [CFG_W-1:0] wr_data
);

	logic [DIM_W-1:0]   dim_x_q;
	logic [DIM_W-1:0]   dim_y_q;
	logic [DIM_W-1:0]   dim_z_q;
	logic [PLANE_W-1:0] plane_q;
	logic [2*DIM_W-1:0] plane_full;

	div_in_t  d1_in;
	div_in_t  d2_in;
	div_in_t  d3_in;
	div_out_t d1_out;
	div_out_t d2_out;
	div_out_t d3_out;
	result_t  res;

	assign busy = 1'b0;

	// extents held clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= DIM_W'(1);
			dim_y_q <= DIM_W'(1);
			dim_z_q <= DIM_W'(1);
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_DIM_X: dim_x_q <= eff_dim(wr_data);
				REG_DIM_Y: dim_y_q <= eff_dim(wr_data);
				REG_DIM_Z: dim_z_q <= eff_dim(wr_data);
				default: ;
			endcase
		end
	end

	assign plane_full = dim_x_q * dim_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= PLANE_W'(1);
		end else begin
			plane_q <= PLANE_W'(plane_full);
		end
	end

	always_comb begin
		d1_in.vld    = start && !busy;
		d1_in.val    = node_index;
		d1_in.side   = '0;
		d2_in.vld    = d1_out.vld;
		d2_in.val    = d1_out.quo;
		d2_in.side.x = d1_out.rem;
		d2_in.side.y = '0;
		d3_in.vld    = d2_out.vld;
		d3_in.val    = d2_out.quo;
		d3_in.side.x = d2_out.side.x;
		d3_in.side.y = d2_out.rem;
	end

	gsn_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (d1_in),
		.divisor  (dim_x_q),
		.out_beat (d1_out)
	);

	gsn_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (d2_in),
		.divisor  (dim_y_q),
		.out_beat (d2_out)
	);

	gsn_div u_div_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_beat  (d3_in),
		.divisor  (dim_z_q),
		.out_beat (d3_out)
	);

	gsn_addr u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.zin    (d3_out),
		.nx     (dim_x_q),
		.ny     (dim_y_q),
		.nz     (dim_z_q),
		.plane  (plane_q),
		.res    (res)
	);

	always_comb begin
		done             = res.vld;
		neighbor_x_minus = res.nbr[NBR_XM];
		neighbor_x_plus  = res.nbr[NBR_XP];
		neighbor_y_minus = res.nbr[NBR_YM];
		neighbor_y_plus  = res.nbr[NBR_YP];
		neighbor_z_minus = res.nbr[NBR_ZM];
		neighbor_z_plus  = res.nbr[NBR_ZP];
		present_mask     = res.mask;
	end

endmodule
`default_nettype wire
